@@ rtl/imutcf_pkg.sv @@
// Constants, codes and helper functions for the IMU tilt complementary filter.
package imutcf_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_HIGH = 3'd4;

    // divider operand widths
    localparam int DIV_W = 56;
    localparam int DEN_W = 17;
    localparam logic [DEN_W-1:0] GYRO_DEN  = 17'd131000;
    localparam logic [DEN_W-1:0] BLEND_DEN = 17'd50;

    // q = (n * RECIP) >> SHIFT, exact for n < 2^51 (gyro) and n < 2^37 (blend)
    localparam int GYRO_SHIFT  = 68;
    localparam int BLEND_SHIFT = 44;
    localparam logic [63:0] GYRO_RECIP =
        64'(((128'd1 << GYRO_SHIFT) + 128'(GYRO_DEN) - 128'd1) / 128'(GYRO_DEN));
    localparam logic [63:0] BLEND_RECIP =
        64'(((128'd1 << BLEND_SHIFT) + 128'(BLEND_DEN) - 128'd1) / 128'(BLEND_DEN));

    // CORDIC datapath widths
    localparam int XY_W = 27;
    localparam int Z_W  = 34;

    // atan(2^-i) in degrees, Q24
    function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            5'd0:  v = 34'sd754974720;
            5'd1:  v = 34'sd445687602;
            5'd2:  v = 34'sd235489088;
            5'd3:  v = 34'sd119537938;
            5'd4:  v = 34'sd60000934;
            5'd5:  v = 34'sd30029717;
            5'd6:  v = 34'sd15018523;
            5'd7:  v = 34'sd7509720;
            5'd8:  v = 34'sd3754917;
            5'd9:  v = 34'sd1877466;
            5'd10: v = 34'sd938734;
            5'd11: v = 34'sd469367;
            5'd12: v = 34'sd234684;
            5'd13: v = 34'sd117342;
            5'd14: v = 34'sd58671;
            5'd15: v = 34'sd29335;
            5'd16: v = 34'sd14668;
            5'd17: v = 34'sd7334;
            5'd18: v = 34'sd3667;
            5'd19: v = 34'sd1833;
            5'd20: v = 34'sd917;
            5'd21: v = 34'sd458;
            5'd22: v = 34'sd229;
            5'd23: v = 34'sd115;
            5'd24: v = 34'sd57;
            5'd25: v = 34'sd29;
            5'd26: v = 34'sd14;
            5'd27: v = 34'sd7;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            5'd30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [DIV_W-1:0] v);
        logic signed [31:0] r;
        if (v > $signed({{(DIV_W-32){1'b0}}, 32'h7FFF_FFFF}))
            r = 32'sh7FFF_FFFF;
        else if (v < $signed({{(DIV_W-32){1'b1}}, 32'h8000_0000}))
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/imu_tilt_complementary_filter_unit.sv @@
// Top level of the IMU tilt complementary filter (pitch and roll).
//
// Usage:
//   s_axis carries one raw sample set per beat; s_axis_tready is high only
//   while the block is idle. m_axis carries one result beat per input beat,
//   the in-band flag on m_axis_tuser. cfg_* writes one register per beat and
//   is always ready; write only while the block is idle.
// Order: the two tilt angles are computed in turn (integer root, then
//   CORDIC, on one shared root unit and one CORDIC unit), then the two gyro
//   increments, then the two blends when in band, on one shared 32x32
//   reciprocal multiplier (4 partial products per quotient), then the
//   result goes to the output register.
//   A new beat is taken only once the previous one has been processed; the
//   root and CORDIC iterations take most of that time.
// Reset: angles clear, the first beat after reset seeds them from the
//   accelerometer, registers take their reset values.
// Stall: the result waits in the output register; a new sample is taken
//   meanwhile, but its result is held back until the previous one is taken.
module imu_tilt_complementary_filter_unit
    import imutcf_pkg::*;
#(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y
    input  logic [79:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pitch, roll, accel_pitch, accel_roll
    output logic [111:0]          m_axis_tdata,
    // in_band
    output logic                  m_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SHR = 24 - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] HALF = (SHR > 0) ? (Z_W'(1) << (SHR - 1)) : '0;
    localparam logic signed [Z_W-1:0] LIM = Z_W'(90) << ANGLE_FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_INIT, S_SQRT, S_CRD_INIT, S_CORDIC, S_CRD_DONE, S_SEED,
        S_DIV_INIT, S_DIV_LOAD, S_DIV, S_DIV_DONE, S_FIN
    } state_t;

    typedef enum logic [1:0] {OP_GX, OP_GY, OP_BP, OP_BR} div_op_t;

    state_t  state_reg;
    div_op_t op_reg;
    logic    ph_reg;
    logic [5:0] cnt_reg;

    logic [1:0]  accel_range_reg, gyro_range_reg;
    logic [7:0]  period_ms_reg;
    logic [10:0] magnitude_low_reg, magnitude_high_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic band_reg, seeded_reg, zero_reg;
    logic signed [31:0] fp_reg, fr_reg, np_reg, nr_reg;
    logic signed [Z_W-1:0] accp_reg, accr_reg;

    logic [47:0] v_reg, res_reg, bit_reg;
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;

    logic signed [DIV_W-1:0] n_reg;
    logic [DIV_W-1:0] m_reg;
    logic [DEN_W-1:0] d_reg;
    logic [127:0] acc_reg;
    logic neg_reg;

    logic m_tvalid_reg, m_tuser_reg;
    logic [111:0] m_tdata_reg;

    // band test on the incoming beat
    logic signed [15:0] in_ax, in_ay, in_az;
    logic [16:0] abs_x, abs_y, abs_z;
    logic [21:0] mag_sum;
    logic in_band;
    always_comb
    begin
        in_ax = s_axis_tdata[15:0];
        in_ay = s_axis_tdata[31:16];
        in_az = s_axis_tdata[47:32];
        abs_x = in_ax[15] ? 17'(-{in_ax[15], in_ax}) : {1'b0, in_ax};
        abs_y = in_ay[15] ? 17'(-{in_ay[15], in_ay}) : {1'b0, in_ay};
        abs_z = in_az[15] ? 17'(-{in_az[15], in_az}) : {1'b0, in_az};
        mag_sum = 22'({3'b0, abs_x} + {3'b0, abs_y} + {3'b0, abs_z}) << accel_range_reg;
        in_band = (mag_sum > {5'b0, magnitude_low_reg, 6'b0})
               && (mag_sum < {5'b0, magnitude_high_reg, 6'b0});
    end

    // root operand
    logic signed [15:0] sel_a, sel_num;
    logic signed [31:0] sq_a, sq_b;
    logic [32:0] sq_sum;
    always_comb
    begin
        sel_a   = ph_reg ? ay_reg : ax_reg;
        sel_num = ph_reg ? ax_reg : ay_reg;
        sq_a    = sel_a * sel_a;
        sq_b    = az_reg * az_reg;
        sq_sum  = {1'b0, sq_a} + {1'b0, sq_b};
    end

    // integer root step
    logic [47:0] rb;
    logic rb_ok;
    always_comb
    begin
        rb = res_reg + bit_reg;
        rb_ok = v_reg >= rb;
    end

    // CORDIC step
    logic [4:0] ci;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0] at;
    logic signed [Z_W-1:0] z_rnd, z_clmp;
    always_comb
    begin
        ci = cnt_reg[4:0];
        xs = x_reg >>> ci;
        ys = y_reg >>> ci;
        at = atan_q24(ci);
        z_rnd = (SHR > 0) ? ((z_reg + HALF) >>> SHR) : z_reg;
        if (zero_reg)
            z_clmp = '0;
        else if (z_rnd > LIM)
            z_clmp = LIM;
        else if (z_rnd < -LIM)
            z_clmp = -LIM;
        else
            z_clmp = z_rnd;
    end

    // divider operands: reciprocal multiply, one 32x32 partial product per cycle
    logic [10:0] pscale;
    logic signed [27:0] gprod;
    logic signed [DIV_W-1:0] n_init, n_abs, q_s, gsum;
    logic gyro_op;
    logic [63:0] recip, prod;
    logic [31:0] mul_a, mul_b;
    logic [127:0] pp;
    logic [DIV_W-1:0] quo;
    always_comb
    begin
        pscale = {3'b0, period_ms_reg} << gyro_range_reg;
        gprod = (op_reg == OP_GX ? gx_reg : gy_reg) * $signed({1'b0, pscale});
        unique case (op_reg)
            OP_GX, OP_GY: n_init = DIV_W'(gprod) <<< ANGLE_FRAC_BITS;
            OP_BP: n_init = DIV_W'(np_reg) * 49 + DIV_W'(accp_reg);
            default: n_init = DIV_W'(nr_reg) * 49 + DIV_W'(accr_reg);
        endcase
        n_abs = n_reg[DIV_W-1] ? -n_reg : n_reg;
        gyro_op = (op_reg == OP_GX) || (op_reg == OP_GY);
        recip = gyro_op ? GYRO_RECIP : BLEND_RECIP;
        mul_a = cnt_reg[1] ? 32'(m_reg[DIV_W-1:32]) : m_reg[31:0];
        mul_b = cnt_reg[0] ? recip[63:32] : recip[31:0];
        prod = {32'b0, mul_a} * {32'b0, mul_b};
        unique case (cnt_reg[1:0])
            2'd0:       pp = {64'b0, prod};
            2'd1, 2'd2: pp = {32'b0, prod, 32'b0};
            default:    pp = {prod, 64'b0};
        endcase
        quo = gyro_op ? DIV_W'(acc_reg >> GYRO_SHIFT) : DIV_W'(acc_reg >> BLEND_SHIFT);
        q_s = neg_reg ? -$signed(quo) : $signed(quo);
        gsum = q_s + DIV_W'(op_reg == OP_GX ? fp_reg : fr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_GX;
            ph_reg <= 1'b0;
            cnt_reg <= '0;
            accel_range_reg <= 2'd0;
            gyro_range_reg <= 2'd0;
            period_ms_reg <= 8'd5;
            magnitude_low_reg <= 11'd128;
            magnitude_high_reg <= 11'd512;
            seeded_reg <= 1'b0;
            fp_reg <= '0;
            fr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ACCEL_RANGE:    accel_range_reg <= cfg_data[1:0];
                    CFG_GYRO_RANGE:     gyro_range_reg <= cfg_data[1:0];
                    CFG_PERIOD_MS:      period_ms_reg <= cfg_data[7:0];
                    CFG_MAGNITUDE_LOW:  magnitude_low_reg <= cfg_data;
                    CFG_MAGNITUDE_HIGH: magnitude_high_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_axis_tready && (state_reg != S_FIN))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        ax_reg <= s_axis_tdata[15:0];
                        ay_reg <= s_axis_tdata[31:16];
                        az_reg <= s_axis_tdata[47:32];
                        gx_reg <= s_axis_tdata[63:48];
                        gy_reg <= s_axis_tdata[79:64];
                        band_reg <= in_band;
                        ph_reg <= 1'b0;
                        state_reg <= S_SQ_INIT;
                    end
                end
                S_SQ_INIT:
                begin
                    v_reg <= {sq_sum[31:0], 16'b0};
                    res_reg <= '0;
                    bit_reg <= 48'd1 << 46;
                    cnt_reg <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (rb_ok)
                    begin
                        v_reg <= v_reg - rb;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd23)
                        state_reg <= S_CRD_INIT;
                end
                S_CRD_INIT:
                begin
                    x_reg <= {2'b0, res_reg[24:0]};
                    y_reg <= XY_W'(sel_num) <<< 8;
                    z_reg <= '0;
                    zero_reg <= (res_reg == '0) && (sel_num == '0);
                    cnt_reg <= '0;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (!y_reg[XY_W-1])
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(CORDIC_STEPS - 1))
                        state_reg <= S_CRD_DONE;
                end
                S_CRD_DONE:
                begin
                    if (!ph_reg)
                    begin
                        accp_reg <= z_clmp;
                        ph_reg <= 1'b1;
                        state_reg <= S_SQ_INIT;
                    end
                    else
                    begin
                        accr_reg <= z_clmp;
                        state_reg <= S_SEED;
                    end
                end
                S_SEED:
                begin
                    if (!seeded_reg)
                    begin
                        fp_reg <= sat32(DIV_W'(accp_reg));
                        fr_reg <= sat32(DIV_W'(accr_reg));
                        seeded_reg <= 1'b1;
                    end
                    op_reg <= OP_GX;
                    state_reg <= S_DIV_INIT;
                end
                S_DIV_INIT:
                begin
                    n_reg <= n_init;
                    d_reg <= gyro_op ? GYRO_DEN : BLEND_DEN;
                    state_reg <= S_DIV_LOAD;
                end
                S_DIV_LOAD:
                begin
                    m_reg <= n_abs + DIV_W'(d_reg >> 1);
                    neg_reg <= n_reg[DIV_W-1];
                    acc_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    acc_reg <= acc_reg + pp;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd3)
                        state_reg <= S_DIV_DONE;
                end
                S_DIV_DONE:
                begin
                    unique case (op_reg)
                        OP_GX:
                        begin
                            np_reg <= sat32(gsum);
                            op_reg <= OP_GY;
                            state_reg <= S_DIV_INIT;
                        end
                        OP_GY:
                        begin
                            nr_reg <= sat32(gsum);
                            op_reg <= OP_BP;
                            state_reg <= band_reg ? S_DIV_INIT : S_FIN;
                        end
                        OP_BP:
                        begin
                            np_reg <= sat32(q_s);
                            op_reg <= OP_BR;
                            state_reg <= S_DIV_INIT;
                        end
                        default:
                        begin
                            nr_reg <= sat32(q_s);
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_FIN:
                begin
                    if (!m_tvalid_reg || m_axis_tready)
                    begin
                        fp_reg <= np_reg;
                        fr_reg <= nr_reg;
                        m_tdata_reg <= {accr_reg[23:0], accp_reg[23:0], nr_reg, np_reg};
                        m_tuser_reg <= band_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule
